### rtl/blbi_pkg.sv
// Shared widths, codes and types of the block log Bloom index.
`timescale 1ns / 1ps
`default_nettype none

package blbi_pkg;

  // Payload widths
  localparam int unsigned KEY_W     = 48;
  localparam int unsigned BLK_NUM_W = 10;
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned WIDE_W    = 40;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned BLOCKS_DEF = 1024;

  // Filter geometry: one row of 64-bit words per block
  localparam int unsigned FILTER_BYTES = 256;
  localparam int unsigned FILTER_BITS  = FILTER_BYTES * 8;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned ROW_WORDS    = FILTER_BITS / WORD_W;
  localparam int unsigned WORD_AW      = $clog2(ROW_WORDS);
  localparam int unsigned BIT_AW       = $clog2(WORD_W);
  localparam int unsigned KEY_IDX_W    = $clog2(FILTER_BITS);

  // Keys per log and bit indexes per key
  localparam int unsigned NUM_KEYS  = 5;
  localparam int unsigned KEY_PAIRS = 3;
  localparam int unsigned SEL_W     = $clog2(NUM_KEYS);
  localparam int unsigned PAIR_W    = $clog2(KEY_PAIRS);
  localparam int unsigned STEP_W    = $clog2(NUM_KEYS * KEY_PAIRS + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [WIDE_W-1:0]  WIDE_MAX  = '1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OLD   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [WIDE_W-1:0]  offset;
  } info_t;

  typedef struct packed {
    logic clr;    // zero one filter word
    logic rd;     // issue a filter word read
    logic set;    // response words get their bit set and written back
    logic flush;  // drop the forwarding entry
  } flt_ctrl_t;

  typedef struct packed {
    logic vld;
    logic hit;    // addressed bit before any set
  } flt_rsp_t;

endpackage

`default_nettype wire

### rtl/blbi_info_mem.sv
// Per-block log count and offset memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module blbi_info_mem #(
  parameter int unsigned BLOCKS = blbi_pkg::BLOCKS_DEF,
  localparam int unsigned RowAw = $clog2(BLOCKS)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [RowAw-1:0]    wr_addr_i,
  input  blbi_pkg::info_t     wr_data_i,
  input  logic                rd_en_i,
  input  logic [RowAw-1:0]    rd_addr_i,
  output blbi_pkg::info_t     rd_data_o
);
  import blbi_pkg::*;

  info_t mem_q [BLOCKS];
  info_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/blbi_filter_unit.sv
// Filter word memory with a read-modify-write pipeline and write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none

module blbi_filter_unit #(
  parameter int unsigned BLOCKS = blbi_pkg::BLOCKS_DEF,
  localparam int unsigned RowAw = $clog2(BLOCKS),
  localparam int unsigned FltAw = RowAw + blbi_pkg::WORD_AW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  blbi_pkg::flt_ctrl_t           ctrl_i,
  input  logic [RowAw-1:0]              row_i,
  input  logic [blbi_pkg::WORD_AW-1:0]  word_i,
  input  logic [blbi_pkg::BIT_AW-1:0]   bit_i,
  input  logic [FltAw-1:0]              clr_addr_i,
  output blbi_pkg::flt_rsp_t            rsp_o
);
  import blbi_pkg::*;

  localparam int unsigned FltDepth = BLOCKS * ROW_WORDS;

  logic [WORD_W-1:0] mem_q [FltDepth];
  logic [WORD_W-1:0] rdata_q;

  logic              pend_vld_q;
  logic [FltAw-1:0]  pend_addr_q;
  logic [BIT_AW-1:0] pend_bit_q;
  logic              set_q;

  logic              lw_vld_q;
  logic [FltAw-1:0]  lw_addr_q;
  logic [WORD_W-1:0] lw_data_q;

  logic [FltAw-1:0]  rd_addr;
  logic              fwd;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] set_word;
  logic              wr_en;

  assign rd_addr  = {row_i, word_i};
  // The write of the previous response lands at the same edge as this read
  assign fwd      = lw_vld_q && (lw_addr_q == pend_addr_q);
  assign cur_word = fwd ? lw_data_q : rdata_q;
  assign set_word = cur_word | (WORD_W'(1) << pend_bit_q);
  assign wr_en    = pend_vld_q && set_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      mem_q[clr_addr_i] <= '0;
    end else if (wr_en) begin
      mem_q[pend_addr_q] <= set_word;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      lw_vld_q   <= 1'b0;
    end else begin
      pend_vld_q <= ctrl_i.rd;
      lw_vld_q   <= ctrl_i.flush ? 1'b0 : wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      pend_addr_q <= rd_addr;
      pend_bit_q  <= bit_i;
      set_q       <= ctrl_i.set;
    end
    if (wr_en) begin
      lw_addr_q <= pend_addr_q;
      lw_data_q <= set_word;
    end
  end

  assign rsp_o.vld = pend_vld_q;
  assign rsp_o.hit = cur_word[pend_bit_q];

  a_clr_rd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.clr && ctrl_i.rd))
    else $error("filter clear and read in the same cycle");

  a_fwd_recent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lw_vld_q |-> $past(pend_vld_q && set_q))
    else $error("forwarding entry does not come from the last write");

  a_set_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && set_q && !ctrl_i.flush) |=> (lw_vld_q && lw_data_q[$past(pend_bit_q)]))
    else $error("written filter word lost its bit");

endmodule

`default_nettype wire

### rtl/block_log_bloom_index.sv
// Top level of the block log Bloom index: request sequencer and block bookkeeping.
// Insert: one filter word read-modify-write per cycle for the fifteen key bits, then
//   the result strobe; next request taken in the strobe cycle.
// Query: strobe after three filter word reads; rejected or out-of-range requests: no reads.
// Reset clears control state, then a clearing pass zeroes filter and count/offset
//   memories with busy_o high.
// Results are shown for one cycle with done_o and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module block_log_bloom_index #(
  parameter int unsigned BLOCKS = blbi_pkg::BLOCKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            command_i,
  input  logic [blbi_pkg::BLK_NUM_W-1:0]  block_number_i,
  input  logic [blbi_pkg::KEY_W-1:0]      address_key_i,
  input  logic [blbi_pkg::KEY_W-1:0]      topic_key_0_i,
  input  logic [blbi_pkg::KEY_W-1:0]      topic_key_1_i,
  input  logic [blbi_pkg::KEY_W-1:0]      topic_key_2_i,
  input  logic [blbi_pkg::KEY_W-1:0]      topic_key_3_i,
  output logic                            done_o,
  output logic [blbi_pkg::STATUS_W-1:0]   status_o,
  output logic                            filter_hit_o,
  output logic [blbi_pkg::COUNT_W-1:0]    block_log_count_o,
  output logic [blbi_pkg::WIDE_W-1:0]     block_log_offset_o,
  output logic [blbi_pkg::BLK_NUM_W-1:0]  newest_block_o,
  output logic [blbi_pkg::WIDE_W-1:0]     total_logs_o
);
  import blbi_pkg::*;

  localparam int unsigned RowAw = $clog2(BLOCKS);
  localparam int unsigned FltAw = RowAw + WORD_AW;
  localparam logic [FltAw-1:0] ClrLast = FltAw'(BLOCKS * ROW_WORDS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;
  localparam logic [1:0] OP_RANGE  = 2'd3;

  localparam logic [STEP_W-1:0] StepsInsert = STEP_W'(NUM_KEYS * KEY_PAIRS);
  localparam logic [STEP_W-1:0] StepsQuery  = STEP_W'(KEY_PAIRS);

  // Control state
  logic [1:0]        state_q, state_d;
  logic [FltAw-1:0]  clr_q;
  logic [1:0]        op_q;
  logic              first_q;
  logic              done_q;
  logic [STEP_W-1:0] steps_q;
  logic [STEP_W-1:0] rd_cnt_q;
  logic [SEL_W-1:0]  key_sel_q;
  logic [PAIR_W-1:0] pair_q;
  logic [BLK_NUM_W-1:0] newest_q;
  logic [WIDE_W-1:0] total_q;

  // Request payload and result
  logic [BLK_NUM_W-1:0] blk_q;
  logic                 open_q;
  logic [KEY_W-1:0]     keys_q [NUM_KEYS];
  logic [STATUS_W-1:0]  status_q;
  logic                 hit_q;
  logic [COUNT_W-1:0]   res_cnt_q;
  logic [WIDE_W-1:0]    res_off_q;

  logic                 accept;
  logic                 in_range;
  logic                 open_in;
  logic                 older_in;
  logic [1:0]           op_in;
  logic [STEP_W-1:0]    steps_in;
  logic                 run;
  logic                 issue;
  logic                 finish;
  logic                 ins_wr;
  logic [KEY_W-1:0]     cur_key;
  logic [KEY_IDX_W-1:0] key_val;
  logic [KEY_IDX_W-1:0] bit_idx;
  logic [WIDE_W:0]      open_sum;
  logic [WIDE_W-1:0]    open_off;
  logic [COUNT_W-1:0]   inc_cnt;
  logic [COUNT_W-1:0]   new_cnt;
  logic [WIDE_W-1:0]    new_off;

  info_t                info_rd;
  info_t                info_rd_data;
  info_t                info_wr_data;
  logic                 info_wr_en;
  logic [RowAw-1:0]     info_wr_addr;
  logic                 info_rd_en;
  logic [RowAw-1:0]     info_rd_addr;

  flt_ctrl_t            flt_ctrl;
  flt_rsp_t             flt_rsp;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign in_range = 32'(block_number_i) < BLOCKS;
  assign open_in  = block_number_i > newest_q;
  assign older_in = block_number_i < newest_q;

  always_comb begin
    if (!in_range) begin
      op_in = OP_RANGE;
    end else if (command_i) begin
      op_in = OP_QUERY;
    end else if (older_in) begin
      op_in = OP_REJECT;
    end else begin
      op_in = OP_INSERT;
    end
  end

  always_comb begin
    case (op_in)
      OP_INSERT: steps_in = StepsInsert;
      OP_QUERY:  steps_in = StepsQuery;
      default:   steps_in = '0;
    endcase
  end

  assign run    = (state_q == ST_RUN);
  assign issue  = run && (rd_cnt_q != steps_q);
  assign finish = run && (rd_cnt_q == steps_q);

  // Bit index of the current key pair: 2047 minus the masked 16-bit pair
  assign cur_key = keys_q[key_sel_q];
  always_comb begin
    case (pair_q)
      2'd0:    key_val = cur_key[KEY_IDX_W-1:0];
      2'd1:    key_val = cur_key[16 +: KEY_IDX_W];
      2'd2:    key_val = cur_key[32 +: KEY_IDX_W];
      default: key_val = '0;
    endcase
  end
  assign bit_idx = ~key_val;

  // Opening a block takes the newest block's offset plus its count
  assign info_rd  = info_rd_data;
  assign open_sum = {1'b0, info_rd.offset} + (WIDE_W + 1)'(info_rd.count);
  assign open_off = open_sum[WIDE_W] ? WIDE_MAX : open_sum[WIDE_W-1:0];
  assign inc_cnt  = (info_rd.count == COUNT_MAX) ? COUNT_MAX : info_rd.count + 1'b1;
  assign new_cnt  = open_q ? COUNT_W'(1) : inc_cnt;
  assign new_off  = open_q ? open_off : info_rd.offset;

  assign ins_wr = run && first_q && (op_q == OP_INSERT);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      info_wr_en   = 1'b1;
      info_wr_addr = clr_q[FltAw-1:WORD_AW];
      info_wr_data = '0;
    end else begin
      info_wr_en          = ins_wr;
      info_wr_addr        = RowAw'(blk_q);
      info_wr_data.count  = new_cnt;
      info_wr_data.offset = new_off;
    end
  end

  assign info_rd_en   = accept && in_range;
  assign info_rd_addr = (!command_i && open_in) ? RowAw'(newest_q) : RowAw'(block_number_i);

  blbi_info_mem #(
    .BLOCKS (BLOCKS)
  ) u_info (
    .clk_i     (clk_i),
    .wr_en_i   (info_wr_en),
    .wr_addr_i (info_wr_addr),
    .wr_data_i (info_wr_data),
    .rd_en_i   (info_rd_en),
    .rd_addr_i (info_rd_addr),
    .rd_data_o (info_rd_data)
  );

  assign flt_ctrl.clr   = (state_q == ST_CLEAR);
  assign flt_ctrl.rd    = issue;
  assign flt_ctrl.set   = (op_q == OP_INSERT);
  assign flt_ctrl.flush = accept;

  blbi_filter_unit #(
    .BLOCKS (BLOCKS)
  ) u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (flt_ctrl),
    .row_i      (RowAw'(blk_q)),
    .word_i     (bit_idx[KEY_IDX_W-1:BIT_AW]),
    .bit_i      (bit_idx[BIT_AW-1:0]),
    .clr_addr_i (clr_q),
    .rsp_o      (flt_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == ClrLast) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_RUN;
      ST_RUN:   if (finish) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      op_q      <= OP_RANGE;
      first_q   <= 1'b0;
      done_q    <= 1'b0;
      steps_q   <= '0;
      rd_cnt_q  <= '0;
      key_sel_q <= '0;
      pair_q    <= '0;
      newest_q  <= '0;
      total_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        op_q      <= op_in;
        first_q   <= 1'b1;
        steps_q   <= steps_in;
        rd_cnt_q  <= '0;
        key_sel_q <= '0;
        pair_q    <= '0;
      end else if (run) begin
        first_q <= 1'b0;
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
          // advance to the next key after its last pair
          if (pair_q == PAIR_W'(KEY_PAIRS - 1)) begin
            pair_q    <= '0;
            key_sel_q <= key_sel_q + 1'b1;
          end else begin
            pair_q <= pair_q + 1'b1;
          end
        end
      end
      if (ins_wr) begin
        newest_q <= blk_q;
        if (total_q != WIDE_MAX) begin
          total_q <= total_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q     <= block_number_i;
      open_q    <= open_in;
      keys_q[0] <= address_key_i;
      keys_q[1] <= topic_key_0_i;
      keys_q[2] <= topic_key_1_i;
      keys_q[3] <= topic_key_2_i;
      keys_q[4] <= topic_key_3_i;
      hit_q     <= (op_in == OP_QUERY);
      res_cnt_q <= '0;
      res_off_q <= '0;
      case (op_in)
        OP_RANGE:  status_q <= STATUS_RANGE;
        OP_REJECT: status_q <= STATUS_OLD;
        default:   status_q <= STATUS_OK;
      endcase
    end else if (run) begin
      if (first_q) begin
        case (op_q)
          OP_INSERT: begin
            res_cnt_q <= new_cnt;
            res_off_q <= new_off;
          end
          OP_QUERY, OP_REJECT: begin
            res_cnt_q <= info_rd.count;
            res_off_q <= info_rd.offset;
          end
          default: begin
            res_cnt_q <= '0;
            res_off_q <= '0;
          end
        endcase
      end
      // a query hits only if every tested bit is set
      if (flt_rsp.vld && (op_q == OP_QUERY)) begin
        hit_q <= hit_q & flt_rsp.hit;
      end
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign filter_hit_o       = hit_q;
  assign block_log_count_o  = res_cnt_q;
  assign block_log_offset_o = res_off_q;
  assign newest_block_o     = newest_q;
  assign total_logs_o       = total_q;

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_total_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_logs_o >= $past(total_logs_o)))
    else $error("total log count went down");

  a_range_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_RANGE)) |->
      (!filter_hit_o && (block_log_count_o == '0) && (block_log_offset_o == '0)))
    else $error("out-of-range result carries block data");

endmodule

`default_nettype wire

### tb/block_log_bloom_index_test.sv
// Self-checking testbench of the block log Bloom index: directed and random requests.
`timescale 1ns / 1ps

module block_log_bloom_index_test;
  import blbi_pkg::*;

  localparam int NUM_BLOCKS     = BLOCKS_DEF;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int ADVANCE_LIMIT  = 1000;
  localparam int IDLE_PERCENT   = 8;
  localparam int SEEN_KEYS_MAX  = 100;
  localparam int SETTLE_CYCLES  = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef logic [NUM_KEYS-1:0][KEY_W-1:0] key_set_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 hit;
    logic [COUNT_W-1:0]   count;
    logic [WIDE_W-1:0]    offset;
    logic [BLK_NUM_W-1:0] newest;
    logic [WIDE_W-1:0]    total;
  } bloom_result_t;

  typedef struct packed {
    logic [BLK_NUM_W-1:0] blk;
    logic [KEY_W-1:0]     key;
  } seen_key_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic                 command_i      = 1'b0;
  logic [BLK_NUM_W-1:0] block_number_i = '0;
  logic [KEY_W-1:0]     address_key_i  = '0;
  logic [KEY_W-1:0]     topic_key_0_i  = '0;
  logic [KEY_W-1:0]     topic_key_1_i  = '0;
  logic [KEY_W-1:0]     topic_key_2_i  = '0;
  logic [KEY_W-1:0]     topic_key_3_i  = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 filter_hit_o;
  logic [COUNT_W-1:0]   block_log_count_o;
  logic [WIDE_W-1:0]    block_log_offset_o;
  logic [BLK_NUM_W-1:0] newest_block_o;
  logic [WIDE_W-1:0]    total_logs_o;

  // Shadow copy of the index
  logic [FILTER_BITS-1:0] filter_bits [NUM_BLOCKS];
  logic [COUNT_W-1:0]     shadow_count [NUM_BLOCKS];
  logic [WIDE_W-1:0]      block_offset [NUM_BLOCKS];
  logic [BLK_NUM_W-1:0]   newest_blk;
  logic [WIDE_W-1:0]      logs_total;

  bloom_result_t pending_results [$];
  seen_key_t     seen_keys [$];
  bloom_result_t front_result;

  bit idle_enable = 1'b1;
  int failures        = 0;
  int results_checked = 0;
  int n_inserts       = 0;
  int n_rejected      = 0;
  int n_queries       = 0;
  int n_hits          = 0;

  block_log_bloom_index #(
    .BLOCKS(NUM_BLOCKS)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .command_i         (command_i),
    .block_number_i    (block_number_i),
    .address_key_i     (address_key_i),
    .topic_key_0_i     (topic_key_0_i),
    .topic_key_1_i     (topic_key_1_i),
    .topic_key_2_i     (topic_key_2_i),
    .topic_key_3_i     (topic_key_3_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .filter_hit_o      (filter_hit_o),
    .block_log_count_o (block_log_count_o),
    .block_log_offset_o(block_log_offset_o),
    .newest_block_o    (newest_block_o),
    .total_logs_o      (total_logs_o)
  );

  always #6 clk_i = ~clk_i;

  // Filter bit addressed by one byte pair of a key; bits above the mask are dropped
  function automatic int unsigned key_bit(input logic [KEY_W-1:0] key, input int pair);
    logic [15:0] pv;
    pv = key[16*pair +: 16];
    return FILTER_BITS - 1 - int'(pv[KEY_IDX_W-1:0]);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return r[KEY_W-1:0];
    endcase
  endfunction

  function automatic key_set_t rand_key_set();
    key_set_t ks;
    for (int k = 0; k < NUM_KEYS; k++) ks[k] = rand_key();
    return ks;
  endfunction

  // Apply one request to the shadow index and return the result it must produce
  task automatic compute_bloom_result(input cmd_e cmd, input logic [BLK_NUM_W-1:0] blk,
                                      input key_set_t keys, output bloom_result_t res);
    logic [WIDE_W:0] off_ext;
    logic [WIDE_W:0] cnt_ext;
    logic [WIDE_W:0] sum;
    res = '0;
    if (int'(blk) >= NUM_BLOCKS) begin
      res.status = STATUS_RANGE;
    end else if (cmd == CMD_QUERY) begin
      res.hit = 1'b1;
      for (int p = 0; p < KEY_PAIRS; p++) begin
        if (!filter_bits[blk][key_bit(keys[0], p)]) res.hit = 1'b0;
      end
      res.count  = shadow_count[blk];
      res.offset = block_offset[blk];
    end else if (blk < newest_blk) begin
      res.status = STATUS_OLD;
      res.count  = shadow_count[blk];
      res.offset = block_offset[blk];
    end else begin
      if (blk > newest_blk) begin
        // Open the new block right after the previous newest one
        off_ext = {1'b0, block_offset[newest_blk]};
        cnt_ext = (WIDE_W + 1)'(shadow_count[newest_blk]);
        sum = off_ext + cnt_ext;
        block_offset[blk] = sum[WIDE_W] ? WIDE_MAX : sum[WIDE_W-1:0];
        shadow_count[blk] = '0;
        newest_blk = blk;
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
        for (int p = 0; p < KEY_PAIRS; p++) filter_bits[blk][key_bit(keys[k], p)] = 1'b1;
      end
      if (shadow_count[blk] != COUNT_MAX) shadow_count[blk] = shadow_count[blk] + 1'b1;
      if (logs_total != WIDE_MAX) logs_total = logs_total + 1'b1;
      res.count  = shadow_count[blk];
      res.offset = block_offset[blk];
    end
    res.newest = newest_blk;
    res.total  = logs_total;
  endtask

  // Send one request, with an occasional gap first, and return at the edge that takes it
  task automatic send_request(input cmd_e cmd, input logic [BLK_NUM_W-1:0] blk,
                              input key_set_t keys);
    bloom_result_t res;
    seen_key_t     sk;
    if (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    command_i      <= cmd;
    block_number_i <= blk;
    address_key_i  <= keys[0];
    topic_key_0_i  <= keys[1];
    topic_key_1_i  <= keys[2];
    topic_key_2_i  <= keys[3];
    topic_key_3_i  <= keys[4];
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    compute_bloom_result(cmd, blk, keys, res);
    pending_results.push_back(res);
    if (cmd == CMD_QUERY) begin
      n_queries++;
      if (res.hit) n_hits++;
    end else if (res.status == STATUS_OLD) begin
      n_rejected++;
    end else begin
      n_inserts++;
      for (int k = 0; k < NUM_KEYS; k++) begin
        sk.blk = blk;
        sk.key = keys[k];
        seen_keys.push_back(sk);
      end
      while (seen_keys.size() > SEEN_KEYS_MAX) void'(seen_keys.pop_front());
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        failures++;
      end else begin
        front_result = pending_results.pop_front();
        results_checked++;
        if (status_o !== front_result.status) begin
          $error("status: expected %0d, got %0d", front_result.status, status_o);
          failures++;
        end
        if (filter_hit_o !== front_result.hit) begin
          $error("filter_hit: expected %0d, got %0d", front_result.hit, filter_hit_o);
          failures++;
        end
        if (block_log_count_o !== front_result.count) begin
          $error("block_log_count: expected %0d, got %0d", front_result.count,
                 block_log_count_o);
          failures++;
        end
        if (block_log_offset_o !== front_result.offset) begin
          $error("block_log_offset: expected %0d, got %0d", front_result.offset,
                 block_log_offset_o);
          failures++;
        end
        if (newest_block_o !== front_result.newest) begin
          $error("newest_block: expected %0d, got %0d", front_result.newest, newest_block_o);
          failures++;
        end
        if (total_logs_o !== front_result.total) begin
          $error("total_logs: expected %0d, got %0d", front_result.total, total_logs_o);
          failures++;
        end
      end
    end
  end

  // Queries straight after reset: every block is empty
  task automatic test_reset_state();
    key_set_t ks;
    ks = '0;
    send_request(CMD_QUERY, 10'd0, ks);
    ks = '1;
    send_request(CMD_QUERY, 10'd0, ks);
    ks = rand_key_set();
    ks[4] = '1;
    send_request(CMD_QUERY, 10'd1023, ks);
  endtask

  task automatic test_first_logs();
    key_set_t ks;
    key_set_t logged;
    ks = '0;
    send_request(CMD_INSERT, 10'd0, ks);
    ks = '1;
    send_request(CMD_INSERT, 10'd0, ks);
    ks = '0;
    send_request(CMD_QUERY, 10'd0, ks);
    ks = '1;
    send_request(CMD_QUERY, 10'd0, ks);
    // Bits above the pair mask do not move the index, a set low bit of the top pair does
    ks = rand_key_set();
    ks[0] = 48'hF800_F800_F800;
    send_request(CMD_QUERY, 10'd0, ks);
    ks[0] = 48'h0001_0000_0000;
    send_request(CMD_QUERY, 10'd0, ks);
    logged = rand_key_set();
    send_request(CMD_INSERT, 10'd0, logged);
    // Topic keys of a query are ignored
    ks = rand_key_set();
    ks[0] = logged[3];
    send_request(CMD_QUERY, 10'd0, ks);
  endtask

  task automatic test_block_opening();
    key_set_t ks;
    key_set_t logged;
    ks = rand_key_set();
    send_request(CMD_INSERT, 10'd1, ks);
    ks = rand_key_set();
    send_request(CMD_INSERT, 10'd1, ks);
    // Skip blocks two to four
    logged = rand_key_set();
    send_request(CMD_INSERT, 10'd5, logged);
    ks = rand_key_set();
    send_request(CMD_QUERY, 10'd3, ks);
    send_request(CMD_INSERT, 10'd2, ks);
    send_request(CMD_INSERT, 10'd1, ks);
    ks[0] = logged[1];
    send_request(CMD_QUERY, 10'd5, ks);
  endtask

  task automatic test_random_traffic();
    key_set_t             ks;
    seen_key_t            sk;
    logic [BLK_NUM_W-1:0] blk;
    cmd_e                 cmd;
    int                   pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_enable = !(i >= 400 && i < 600);
      if (i == 700) drain_results();
      pick = $urandom_range(0, 99);
      ks = rand_key_set();
      if (pick < 35) begin
        cmd = CMD_QUERY;
        if (seen_keys.size() != 0 && $urandom_range(0, 2) != 0) begin
          sk = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
          blk = sk.blk;
          ks[0] = sk.key;
        end else begin
          blk = BLK_NUM_W'($urandom_range(0, NUM_BLOCKS - 1));
        end
      end else begin
        cmd = CMD_INSERT;
        if (pick < 85) begin
          blk = newest_blk;
        end else if (pick < 95) begin
          // Advance slowly so the top block is left for the last test
          if (newest_blk < ADVANCE_LIMIT) blk = BLK_NUM_W'(newest_blk + $urandom_range(1, 3));
          else blk = newest_blk;
        end else begin
          blk = BLK_NUM_W'($urandom_range(0, newest_blk));
        end
      end
      send_request(cmd, blk, ks);
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_top_block();
    key_set_t ks;
    ks = rand_key_set();
    send_request(CMD_INSERT, 10'd1023, ks);
    ks = '1;
    send_request(CMD_INSERT, 10'd1023, ks);
    send_request(CMD_INSERT, 10'd0, ks);
    send_request(CMD_INSERT, 10'd1022, ks);
    send_request(CMD_QUERY, 10'd1023, ks);
    ks = rand_key_set();
    send_request(CMD_QUERY, 10'd512, ks);
  endtask

  initial begin
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      filter_bits[b]  = '0;
      shadow_count[b] = '0;
      block_offset[b] = '0;
    end
    newest_blk = '0;
    logs_total = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_first_logs();
    test_block_opening();
    drain_results();
    test_random_traffic();
    test_top_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d inserts, %0d rejected inserts, %0d queries (%0d hits).",
             n_inserts + n_rejected + n_queries, n_inserts, n_rejected, n_queries, n_hits);
    $display("Newest block %0d, %0d logs indexed, %0d results checked, %0d mismatches.",
             newest_blk, logs_total, results_checked, failures);
    if (failures == 0) begin
      $display("block_log_bloom_index test passed");
    end else begin
      $display("block_log_bloom_index test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("block_log_bloom_index test failed");
    $finish;
  end

endmodule
